// ----- sv/dmjs_pkg.sv -----
// ----------------------------------------------------------------------------
// dmjs_pkg
// types and codes shared by the job selector chain and its top level
// ----------------------------------------------------------------------------
package dmjs_pkg;

    // slot field wide enough for 64 jobs, though job ids in the items hold only 16
    localparam int SLOT_W = 6;

    typedef enum logic [2:0] {
        K_CREATE_PER  = 3'd0,
        K_CREATE_APER = 3'd1,
        K_TRIGGER     = 3'd2,
        K_COMPLETE    = 3'd3,
        K_SCHEDULE    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_NONE      = 3'd3,
        ST_WRONG     = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  job_id;
        logic [31:0] period;
        logic [7:0]  user_priority;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [3:0] result_job;
        logic       found;
        logic [2:0] status;
    } t_out_item;

    // one job as held by a cell
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       period;
        logic [7:0]        prio;
        logic              periodic;
        logic [31:0]       rel_ms;
        logic              wants;
    } t_job;

    // command broadcast to every cell
    typedef struct packed {
        logic              insert;
        logic              trig;
        logic              comp;
        logic [SLOT_W-1:0] id;
        logic [31:0]       now_ms;
        t_job              new_job;
    } t_cmd;

endpackage

// ----- sv/deadline_monotonic_job_selector_top.sv -----
// ----------------------------------------------------------------------------
// deadline_monotonic_job_selector_top
// deadline-monotonic job table with create, trigger, complete and schedule
// ----------------------------------------------------------------------------
// usage
//   input channel i_valid / o_ready carries one item (i_item); each item with
//   a known kind gives one result item on o_valid / i_ready (o_result)
//   one item is in work at a time: accepted into S_EXEC, where create,
//   trigger and complete finish; schedule goes on to S_PICK to pick the
//   first ready cell of the chain
//   a new item is accepted only when the block is back in S_IDLE, after
//   the execute step and, for schedule, the first-ready pick
//   the result register lets a new item be accepted while a result waits;
//   a stalled receiver holds the executing item, which changes no state
//   until its result can be loaded
//   reset clears the job count and the cell valid bits at once; no sweep
//   an unknown kind is dropped without result
// ----------------------------------------------------------------------------
module deadline_monotonic_job_selector_top #(
    parameter int MAX_JOBS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dmjs_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output dmjs_pkg::t_out_item o_result
);
    import dmjs_pkg::*;

    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_PICK} t_state;

    t_state              r_state;
    t_in_item            r_item;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_valid;
    t_out_item           r_out;
    logic [MAX_JOBS-1:0] r_rdy;

    t_cmd                w_cmd;
    t_job                w_jobs [MAX_JOBS];
    logic [MAX_JOBS-1:0] w_ready;
    logic [MAX_JOBS-1:0] w_match_per;
    logic                w_out_free;
    logic                w_full;
    logic                w_unknown;
    logic                w_is_per;
    logic [MAX_JOBS-1:0] w_first;
    logic [SLOT_W-1:0]   w_pick_slot;
    logic                w_do;
    logic                w_load;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;
    assign w_out_free = !r_out_valid || i_ready;

    assign w_full    = (r_count == CNT_W'(MAX_JOBS));
    assign w_unknown = ({{(32-4){1'b0}}, r_item.job_id} >= 32'(r_count));
    assign w_is_per  = |w_match_per;
    // state changes only in the cycle the result gets loaded
    assign w_do      = (r_state == S_EXEC) && w_out_free;
    // a result register load in this cycle
    assign w_load    = w_out_free &&
                       (((r_state == S_EXEC) && (r_item.kind < K_SCHEDULE)) ||
                        (r_state == S_PICK));

    always_comb begin
        w_cmd                  = '0;
        w_cmd.id               = SLOT_W'(r_item.job_id);
        w_cmd.now_ms           = r_item.now_ms;
        w_cmd.new_job.valid    = 1'b1;
        w_cmd.new_job.slot     = SLOT_W'(r_count);
        w_cmd.new_job.period   = r_item.period;
        w_cmd.new_job.prio     = r_item.user_priority;
        w_cmd.new_job.periodic = (r_item.kind == K_CREATE_PER);
        w_cmd.new_job.rel_ms   = (r_item.kind == K_CREATE_PER) ?
                                 (r_item.now_ms + r_item.period) : 32'd0;
        w_cmd.new_job.wants    = 1'b0;
        if (w_do) begin
            case (r_item.kind)
                K_CREATE_PER, K_CREATE_APER: w_cmd.insert = !w_full;
                K_TRIGGER:                   w_cmd.trig   = !w_unknown;
                K_COMPLETE:                  w_cmd.comp   = !w_unknown;
                default:                     ;
            endcase
        end
    end

    dmjs_chain #(.MAX_JOBS(MAX_JOBS)) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_jobs      (w_jobs),
        .o_ready     (w_ready),
        .o_match_per (w_match_per)
    );

    // lowest set bit of the registered ready vector is the winning cell
    assign w_first = r_rdy & (~r_rdy + MAX_JOBS'(1));

    always_comb begin
        w_pick_slot = '0;
        for (int k = 0; k < MAX_JOBS; k++) begin
            w_pick_slot = w_pick_slot | (w_first[k] ? w_jobs[k].slot : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item  <= i_item;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_rdy <= w_ready;
                    if (r_item.kind == K_SCHEDULE) begin
                        r_state <= S_PICK;
                    end else if (r_item.kind > K_SCHEDULE) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out.found <= 1'b0;
                        r_state     <= S_IDLE;
                        case (r_item.kind)
                            K_CREATE_PER, K_CREATE_APER: begin
                                if (w_full) begin
                                    r_out.result_job <= 4'd0;
                                    r_out.status     <= ST_FULL;
                                end else begin
                                    r_out.result_job <= 4'(r_count);
                                    r_out.status     <= ST_OK;
                                    r_count          <= r_count + CNT_W'(1);
                                end
                            end
                            K_TRIGGER: begin
                                r_out.result_job <= r_item.job_id;
                                r_out.status     <= w_unknown ? ST_UNKNOWN :
                                                    (w_is_per ? ST_WRONG : ST_OK);
                            end
                            default: begin
                                r_out.result_job <= r_item.job_id;
                                r_out.status     <= w_unknown ? ST_UNKNOWN : ST_OK;
                            end
                        endcase
                    end
                end
                S_PICK: begin
                    if (w_out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out.found      <= |r_rdy;
                        r_out.result_job <= (|r_rdy) ? w_pick_slot[3:0] : 4'd0;
                        r_out.status     <= (|r_rdy) ? ST_OK : ST_NONE;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.found |-> o_result.status == ST_OK)
        else $error("found result without ok status");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_JOBS))
        else $error("job count beyond table size");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while one is in work");
`endif

endmodule

// ----- sv/dmjs_cell.sv -----
// ----------------------------------------------------------------------------
// dmjs_cell
// one place of the sorted job chain: insert shift, trigger, complete, ready
// ----------------------------------------------------------------------------
module dmjs_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dmjs_pkg::t_cmd i_cmd,
    input  dmjs_pkg::t_job i_prev_job,
    input  logic           i_prev_ins,
    output dmjs_pkg::t_job o_job,
    output logic           o_ins,
    output logic           o_match_per,
    output logic           o_ready
);
    import dmjs_pkg::*;

    t_job r_job;
    t_job n_job;
    logic w_before;
    logic w_match;

    // new job goes in front of this one
    assign w_before = r_job.valid &&
        ((r_job.period > i_cmd.new_job.period) ||
         ((r_job.period == i_cmd.new_job.period) && (r_job.prio < i_cmd.new_job.prio)));
    assign o_ins       = w_before || !r_job.valid;
    assign w_match     = r_job.valid && (r_job.slot == i_cmd.id);
    assign o_match_per = w_match && r_job.periodic;
    assign o_ready     = r_job.valid &&
        (r_job.periodic ? (r_job.rel_ms <= i_cmd.now_ms) : r_job.wants);
    assign o_job       = r_job;

    always_comb begin
        n_job = r_job;
        if (i_cmd.insert) begin
            if (o_ins && i_prev_ins) begin
                n_job = i_prev_job;
            end else if (o_ins) begin
                n_job = i_cmd.new_job;
            end
        end else if (i_cmd.trig && w_match && !r_job.periodic) begin
            n_job.wants = 1'b1;
        end else if (i_cmd.comp && w_match) begin
            if (r_job.periodic) begin
                n_job.rel_ms = r_job.rel_ms + r_job.period;
            end else begin
                n_job.wants = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job.valid <= 1'b0;
        end else begin
            r_job.valid <= n_job.valid;
        end
        r_job.slot     <= n_job.slot;
        r_job.period   <= n_job.period;
        r_job.prio     <= n_job.prio;
        r_job.periodic <= n_job.periodic;
        r_job.rel_ms   <= n_job.rel_ms;
        r_job.wants    <= n_job.wants;
    end

endmodule

// ----- sv/dmjs_chain.sv -----
// ----------------------------------------------------------------------------
// dmjs_chain
// row of job cells in priority order, cell 0 first
// ----------------------------------------------------------------------------
module dmjs_chain #(
    parameter int MAX_JOBS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dmjs_pkg::t_cmd i_cmd,
    output dmjs_pkg::t_job o_jobs [MAX_JOBS],
    output logic [MAX_JOBS-1:0] o_ready,
    output logic [MAX_JOBS-1:0] o_match_per
);
    import dmjs_pkg::*;

    t_job w_job [MAX_JOBS];
    logic [MAX_JOBS-1:0] w_ins;
    t_job w_zero;

    assign w_zero = '0;

    for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
        dmjs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (i_cmd),
            .i_prev_job  ((k == 0) ? w_zero : w_job[(k == 0) ? 0 : k-1]),
            .i_prev_ins  ((k == 0) ? 1'b0 : w_ins[(k == 0) ? 0 : k-1]),
            .o_job       (w_job[k]),
            .o_ins       (w_ins[k]),
            .o_match_per (o_match_per[k]),
            .o_ready     (o_ready[k])
        );
        assign o_jobs[k] = w_job[k];
    end

endmodule

// ----- verif/deadline_monotonic_job_selector_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_monotonic_job_selector_top_tb
// checks job creation, trigger, complete and schedule of the job selector
// against a behavioural job table kept in the bench; items come from a queue,
// results are compared in order, with random idling on both channels
// ----------------------------------------------------------------------------
module deadline_monotonic_job_selector_top_tb;
    import dmjs_pkg::*;

    localparam int NJOBS     = 16;
    localparam int MAX_CYCLE = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_result;

    deadline_monotonic_job_selector_top #(.MAX_JOBS(NJOBS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(o_result)
    );

    // clock, 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // job table mirror
    logic [3:0]  chain_q [NJOBS];
    int          njobs_q = 0;
    logic [31:0] per_q   [NJOBS];
    logic [7:0]  prio_q  [NJOBS];
    logic        isper_q [NJOBS];
    logic [31:0] rel_q   [NJOBS];
    logic        wants_q [NJOBS];

    t_in_item  pending_items[$];
    t_out_item awaited_results[$];

    int  n_mismatch = 0;
    int  cycle_cnt  = 0;
    bit  calm;          // no idling in the last part of the run
    bit  hold_go = 1'b0;
    int  hold_rx;       // long receiver hold-off, counted in its own process
    int  tx_gap;
    int  rx_gap;

    // work out the result of one accepted item and update the mirror
    function automatic void predict_job_table(input t_in_item it);
        t_out_item r;
        int        pos;
        int        k;
        logic [3:0] s;
        r = '0;
        case (it.kind)
            K_CREATE_PER, K_CREATE_APER: begin
                if (njobs_q >= NJOBS) begin
                    r.status = ST_FULL;
                end else begin
                    per_q[njobs_q]   = it.period;
                    prio_q[njobs_q]  = it.user_priority;
                    isper_q[njobs_q] = (it.kind == K_CREATE_PER);
                    rel_q[njobs_q]   = (it.kind == K_CREATE_PER) ?
                                       it.now_ms + it.period : 32'd0;
                    wants_q[njobs_q] = 1'b0;
                    // older jobs stay ahead on a full tie
                    pos = 0;
                    while (pos < njobs_q &&
                           !(per_q[chain_q[pos]] > it.period ||
                             (per_q[chain_q[pos]] == it.period &&
                              prio_q[chain_q[pos]] < it.user_priority)))
                        pos++;
                    for (k = njobs_q; k > pos; k--)
                        chain_q[k] = chain_q[k-1];
                    chain_q[pos] = njobs_q[3:0];
                    r.result_job = njobs_q[3:0];
                    r.status     = ST_OK;
                    njobs_q++;
                end
            end
            K_TRIGGER: begin
                r.result_job = it.job_id;
                if (it.job_id >= njobs_q)        r.status = ST_UNKNOWN;
                else if (isper_q[it.job_id])     r.status = ST_WRONG;
                else begin
                    wants_q[it.job_id] = 1'b1;
                    r.status = ST_OK;
                end
            end
            K_COMPLETE: begin
                r.result_job = it.job_id;
                if (it.job_id >= njobs_q) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    if (isper_q[it.job_id])
                        rel_q[it.job_id] = rel_q[it.job_id] + per_q[it.job_id];
                    else
                        wants_q[it.job_id] = 1'b0;
                    r.status = ST_OK;
                end
            end
            K_SCHEDULE: begin
                r.status = ST_NONE;
                for (k = 0; k < njobs_q; k++) begin
                    s = chain_q[k];
                    if (isper_q[s] ? (rel_q[s] <= it.now_ms) : wants_q[s]) begin
                        r.result_job = s;
                        r.found      = 1'b1;
                        r.status     = ST_OK;
                        break;
                    end
                end
            end
            default: return;  // unknown kind, no result
        endcase
        awaited_results.push_back(r);
    endfunction

    function automatic t_in_item job_item(input logic [2:0] kd, input logic [3:0] id,
                                          input logic [31:0] per, input logic [7:0] pr,
                                          input logic [31:0] now);
        t_in_item it;
        it.kind          = kd;
        it.job_id        = id;
        it.period        = per;
        it.user_priority = pr;
        it.now_ms        = now;
        return it;
    endfunction

    // random item; small periods and times cluster so that jobs become ready
    function automatic t_in_item rand_item(input int njob_hint);
        t_in_item it;
        int       sel;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom}));
        sel = $urandom_range(0, 99);
        if (sel < 10)      it.kind = K_CREATE_PER;
        else if (sel < 18) it.kind = K_CREATE_APER;
        else if (sel < 38) it.kind = K_TRIGGER;
        else if (sel < 58) it.kind = K_COMPLETE;
        else if (sel < 97) it.kind = K_SCHEDULE;
        else               it.kind = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 3) != 0) begin
            it.period        = $urandom_range(0, 40);
            it.now_ms        = $urandom_range(0, 400);
            it.user_priority = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 7) != 0)
            it.job_id = 4'($urandom_range(0, (njob_hint > 0) ? njob_hint - 1 : 0));
        return it;
    endfunction

    // driver: offers items from the queue, idles in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else if (!i_valid || o_ready) begin
            // previous item (if any) was accepted this edge
            if (tx_gap > 0) begin
                tx_gap  <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                tx_gap  <= $urandom_range(1, 14) - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_item  <= pending_items.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // prediction on acceptance at the input
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            predict_job_table(i_item);
    end

    // long receiver hold-off
    initial begin
        hold_rx = 0;
        wait (hold_go);
        @(posedge i_clk);
        hold_rx <= 300;
        @(posedge i_clk);
        while (hold_rx > 0) begin
            hold_rx <= hold_rx - 1;
            @(posedge i_clk);
        end
    end

    // monitor: checks results and drives the receiver's ready
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap  <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (awaited_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result: job %0d found %0d status %0d",
                                 o_result.result_job, o_result.found, o_result.status);
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (o_result !== exp_r) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch: exp job %0d found %0d status %0d, got %0d %0d %0d",
                                     exp_r.result_job, exp_r.found, exp_r.status,
                                     o_result.result_job, o_result.found, o_result.status);
                    end
                end
            end
            if (hold_rx > 0) begin
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap  <= rx_gap - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                rx_gap  <= $urandom_range(1, 14) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic drain_all();
        while (pending_items.size() > 0 || i_valid || awaited_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int idx;
        int hint;
        calm       = 1'b0;
        i_rst_n    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, special cases
        pending_items.push_back(job_item(K_SCHEDULE, 4'd0, 32'd0, 8'd0, 32'hFFFF_FFFF));
        pending_items.push_back(job_item(K_TRIGGER, 4'd15, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_COMPLETE, 4'd0, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_CREATE_PER, 4'd0, 32'hFFFF_FFFF, 8'hFF,
                                         32'hFFFF_FFFF));
        pending_items.push_back(job_item(K_CREATE_APER, 4'd0, 32'd5, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_CREATE_APER, 4'd0, 32'd5, 8'd9, 32'd0));
        pending_items.push_back(job_item(K_CREATE_APER, 4'd0, 32'd5, 8'd9, 32'd0));
        pending_items.push_back(job_item(K_TRIGGER, 4'd0, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(3'd7, 4'd0, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_SCHEDULE, 4'd0, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_TRIGGER, 4'd1, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_SCHEDULE, 4'd0, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_COMPLETE, 4'd1, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_COMPLETE, 4'd0, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_SCHEDULE, 4'd0, 32'd0, 8'd0, 32'hFFFF_FFFE));
        pending_items.push_back(job_item(K_COMPLETE, 4'd0, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_SCHEDULE, 4'd0, 32'd0, 8'd0, 32'hFFFF_FFFD));
        pending_items.push_back(job_item(K_COMPLETE, 4'd9, 32'd0, 8'd0, 32'd0));
        pending_items.push_back(job_item(K_TRIGGER, 4'd9, 32'd0, 8'd0, 32'd0));
        drain_all();

        // receiver holds off while the sender keeps offering
        hold_go = 1'b1;
        for (idx = 0; idx < 30; idx++)
            pending_items.push_back(rand_item(4));
        drain_all();

        // random rounds of 200 items, the first 20 aimed at job ids 0 to 3; later rounds calm
        for (idx = 0; idx < 1550; idx++) begin
            hint = (idx % 200 < 20) ? 4 : 16;
            pending_items.push_back(rand_item(hint));
            if (idx == 1400) begin
                drain_all();       // sender pauses until all results are in
                calm = 1'b1;
            end
        end
        drain_all();
        repeat (20) @(posedge i_clk);

        if (n_mismatch == 0 && awaited_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
